[rtl/core/mjdlt_pkg.sv]
// shared types, constants and tables for the mjd to local date/time unit
package mjdlt_pkg;

    // pipeline depth, one register stage per entry
    localparam int MJDLT_STAGES = 8;

    // date conversion constants
    localparam logic [21:0] MJDLT_J_OFS = 22'(2400001 + 68569);
    localparam int unsigned MJDLT_CENT_DAYS = 146097;
    localparam int unsigned MJDLT_C_MIN = 67;
    localparam int unsigned MJDLT_C_SPAN = 4;
    localparam int unsigned MJDLT_C_EPOCH = 49;
    localparam int unsigned MJDLT_YR_NUM = 4000;
    localparam int unsigned MJDLT_YR_DEN = 1461001;
    localparam int unsigned MJDLT_YR_SHIFT = 24;
    localparam logic [15:0] MJDLT_YR_RECIP =
        16'((64'(MJDLT_YR_NUM) << MJDLT_YR_SHIFT) / 64'(MJDLT_YR_DEN));
    localparam int unsigned MJDLT_QUAD_DAYS = 1461;
    localparam int unsigned MJDLT_MAR_OFS = 31;
    localparam int unsigned MJDLT_MON_NUM = 80;
    localparam int unsigned MJDLT_MON_DEN = 2447;
    localparam int unsigned MJDLT_MON_MAX = 16;
    localparam int unsigned MJDLT_MON_WRAP = 11;

    // time constants
    localparam int unsigned MJDLT_HALF_MIN = 30;
    localparam int unsigned MJDLT_HOUR_MIN = 60;
    localparam int unsigned MJDLT_DAY_HOURS = 24;

    typedef struct packed {
        logic [16:0] mjd;
        logic [4:0]  utc_hour;
        logic [5:0]  utc_minute;
        logic        offset_present;
        logic        offset_negative;
        logic [4:0]  offset_half_hours;
    } mjdlt_req_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  local_hour;
        logic [5:0]  local_minute;
    } mjdlt_rsp_t;

    // per-stage control from the handshake logic to the datapaths
    typedef struct packed {
        logic [MJDLT_STAGES-1:0] load;
        logic [MJDLT_STAGES-1:0] valid;
    } mjdlt_ctl_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
    } mjdlt_tm_t;

    // day offset of each shifted month: (2447 * mm) / 80
    typedef logic [31:0][9:0] mjdlt_dbase_t;

    function automatic mjdlt_dbase_t mjdlt_dbase_build();
        mjdlt_dbase_t t;
        for (int i = 0; i < 32; i++)
        begin
            t[i] = 10'((MJDLT_MON_DEN * i) / MJDLT_MON_NUM);
        end
        return t;
    endfunction

    localparam mjdlt_dbase_t MJDLT_DAY_BASE = mjdlt_dbase_build();

    // first day of the selected century: (146097 * c + 3) / 4
    function automatic logic [21:0] mjdlt_cent_base(input logic [2:0] c_idx);
        int unsigned v;
        v = MJDLT_CENT_DAYS * (MJDLT_C_MIN + 32'(c_idx)) + 3;
        return 22'(v >> 2);
    endfunction

endpackage

[rtl/core/mjdlt_ctrl.sv]
// stage valid bits and per-stage load enables for the pipeline
module mjdlt_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output mjdlt_pkg::mjdlt_ctl_t          ctl
);

    logic [mjdlt_pkg::MJDLT_STAGES-1:0] valid_reg;
    logic [mjdlt_pkg::MJDLT_STAGES-1:0] valid_next;
    logic [mjdlt_pkg::MJDLT_STAGES-1:0] ready;
    logic [mjdlt_pkg::MJDLT_STAGES-1:0] feed;

    // a stage may take new data when it is empty or its content moves on
    always_comb
    begin
        ready[mjdlt_pkg::MJDLT_STAGES-1] =
            !valid_reg[mjdlt_pkg::MJDLT_STAGES-1] || !rsp_stall;
        for (int k = mjdlt_pkg::MJDLT_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        feed[0] = req_valid;
        for (int k = 1; k < mjdlt_pkg::MJDLT_STAGES; k++)
        begin
            feed[k] = valid_reg[k-1];
        end
        for (int k = 0; k < mjdlt_pkg::MJDLT_STAGES; k++)
        begin
            valid_next[k] = ready[k] ? feed[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load  = ready & feed;
    assign ctl.valid = valid_reg;
    assign req_stall = !ready[0];
    assign rsp_valid = valid_reg[mjdlt_pkg::MJDLT_STAGES-1];

endmodule

[rtl/core/mjdlt_date.sv]
// pipelined mjd to gregorian year, month and day
module mjdlt_date (
    input  logic                            clk,
    input  logic [mjdlt_pkg::MJDLT_STAGES-1:0] load,
    input  logic [16:0]                     mjd,
    output logic [11:0]                     year,
    output logic [3:0]                      month,
    output logic [4:0]                      day
);

    // stage 0: julian day and century index
    logic [21:0] s0_j_reg;
    logic [2:0]  s0_c_reg;
    logic [21:0] j_next;
    logic [23:0] j4;
    logic [2:0]  c_next;

    always_comb
    begin
        j_next = 22'(mjd) + mjdlt_pkg::MJDLT_J_OFS;
        j4     = {j_next, 2'b00};
        c_next = '0;
        for (int i = 0; i < mjdlt_pkg::MJDLT_C_SPAN; i++)
        begin
            if (j4 >= 24'(mjdlt_pkg::MJDLT_CENT_DAYS * (mjdlt_pkg::MJDLT_C_MIN + 1 + i)))
            begin
                c_next = 3'(i + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_j_reg <= j_next;
            s0_c_reg <= c_next;
        end
    end

    // stage 1: day within the cycle
    logic [15:0] s1_j1_reg;
    logic [2:0]  s1_c_reg;
    logic [21:0] j1_full;

    assign j1_full = s0_j_reg - mjdlt_pkg::mjdlt_cent_base(s0_c_reg);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s1_j1_reg <= j1_full[15:0];
            s1_c_reg  <= s0_c_reg;
        end
    end

    // stage 2: reciprocal product for the year-in-cycle estimate
    logic [30:0] s2_prod_reg;
    logic [15:0] s2_j1_reg;
    logic [2:0]  s2_c_reg;
    logic [16:0] x1;
    logic [32:0] prod_full;

    assign x1        = 17'(s1_j1_reg) + 17'd1;
    assign prod_full = 33'(x1) * 33'(mjdlt_pkg::MJDLT_YR_RECIP);

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s2_prod_reg <= prod_full[30:0];
            s2_j1_reg   <= s1_j1_reg;
            s2_c_reg    <= s1_c_reg;
        end
    end

    // stage 3: remainder of the estimate
    logic [6:0]  s3_q0_reg;
    logic [21:0] s3_rem_reg;
    logic [15:0] s3_j1_reg;
    logic [2:0]  s3_c_reg;
    logic [6:0]  q0;
    logic [16:0] x2;
    logic [27:0] num;
    logic [27:0] sub;
    logic [27:0] rem_full;

    always_comb
    begin
        q0       = s2_prod_reg[mjdlt_pkg::MJDLT_YR_SHIFT +: 7];
        x2       = 17'(s2_j1_reg) + 17'd1;
        num      = 28'(x2) * 28'(mjdlt_pkg::MJDLT_YR_NUM);
        sub      = 28'(q0) * 28'(mjdlt_pkg::MJDLT_YR_DEN);
        rem_full = num - sub;
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s3_q0_reg  <= q0;
            s3_rem_reg <= rem_full[21:0];
            s3_j1_reg  <= s2_j1_reg;
            s3_c_reg   <= s2_c_reg;
        end
    end

    // stage 4: corrected year within the cycle
    logic [6:0]  s4_yy_reg;
    logic [15:0] s4_j1_reg;
    logic [2:0]  s4_c_reg;
    logic [6:0]  yy_next;

    assign yy_next = s3_q0_reg
        + 7'(s3_rem_reg >= 22'(mjdlt_pkg::MJDLT_YR_DEN));

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s4_yy_reg <= yy_next;
            s4_j1_reg <= s3_j1_reg;
            s4_c_reg  <= s3_c_reg;
        end
    end

    // stage 5: day within the march-based year
    logic [8:0]  s5_j2_reg;
    logic [6:0]  s5_yy_reg;
    logic [2:0]  s5_c_reg;
    logic [17:0] quad;
    logic [17:0] j2_full;

    always_comb
    begin
        quad    = 18'(s4_yy_reg) * 18'(mjdlt_pkg::MJDLT_QUAD_DAYS);
        j2_full = 18'(s4_j1_reg) + 18'(mjdlt_pkg::MJDLT_MAR_OFS) - (quad >> 2);
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s5_j2_reg <= j2_full[8:0];
            s5_yy_reg <= s4_yy_reg;
            s5_c_reg  <= s4_c_reg;
        end
    end

    // stage 6: shifted month by threshold compares
    logic [4:0]  s6_mm_reg;
    logic [8:0]  s6_j2_reg;
    logic [6:0]  s6_yy_reg;
    logic [2:0]  s6_c_reg;
    logic [15:0] p80;
    logic [4:0]  mm_next;

    always_comb
    begin
        p80     = 16'(s5_j2_reg) * 16'(mjdlt_pkg::MJDLT_MON_NUM);
        mm_next = '0;
        for (int k = 1; k <= mjdlt_pkg::MJDLT_MON_MAX; k++)
        begin
            if (p80 >= 16'(mjdlt_pkg::MJDLT_MON_DEN * k))
            begin
                mm_next = 5'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s6_mm_reg <= mm_next;
            s6_j2_reg <= s5_j2_reg;
            s6_yy_reg <= s5_yy_reg;
            s6_c_reg  <= s5_c_reg;
        end
    end

    // stage 7: day, month and year
    logic [11:0] s7_year_reg;
    logic [3:0]  s7_month_reg;
    logic [4:0]  s7_day_reg;
    logic [9:0]  day_full;
    logic        wrap;
    logic [4:0]  month_full;
    logic [11:0] year_base;
    logic [11:0] year_next;

    always_comb
    begin
        day_full   = 10'(s6_j2_reg) - mjdlt_pkg::MJDLT_DAY_BASE[s6_mm_reg];
        wrap       = s6_mm_reg >= 5'(mjdlt_pkg::MJDLT_MON_WRAP);
        month_full = s6_mm_reg + 5'd2 - (wrap ? 5'd12 : 5'd0);
        year_base  = 12'd100 * (12'(mjdlt_pkg::MJDLT_C_MIN - mjdlt_pkg::MJDLT_C_EPOCH)
                     + 12'(s6_c_reg));
        year_next  = year_base + 12'(s6_yy_reg) + 12'(wrap);
    end

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            s7_year_reg  <= year_next;
            s7_month_reg <= month_full[3:0];
            s7_day_reg   <= day_full[4:0];
        end
    end

    assign year  = s7_year_reg;
    assign month = s7_month_reg;
    assign day   = s7_day_reg;

endmodule

[rtl/core/mjdlt_time.sv]
// local offset applied to the utc time, then aligned with the date pipeline
module mjdlt_time (
    input  logic                            clk,
    input  logic [mjdlt_pkg::MJDLT_STAGES-1:0] load,
    input  logic [4:0]                      utc_hour,
    input  logic [5:0]                      utc_minute,
    input  logic                            offset_present,
    input  logic                            offset_negative,
    input  logic [4:0]                      offset_half_hours,
    output mjdlt_pkg::mjdlt_tm_t            tm
);

    // stage 0: minute in range and signed hour carry count
    logic [5:0]        s0_min_reg;
    logic signed [5:0] s0_n_reg;
    logic [4:0]        s0_h_reg;
    logic              half_on;
    logic              neg;
    logic [3:0]        whole;
    logic signed [7:0] mp;
    logic signed [5:0] f;
    logic [5:0]        min_next;
    logic signed [5:0] hh_s;
    logic signed [5:0] n_next;

    always_comb
    begin
        half_on = offset_present & offset_half_hours[0];
        neg     = offset_present & offset_negative;
        whole   = offset_present ? offset_half_hours[4:1] : 4'd0;
        mp      = $signed({2'b00, utc_minute});
        if (half_on)
        begin
            mp = neg ? mp - 8'sd30 : mp + 8'sd30;
        end
        if (mp < 8'sd0)
        begin
            f        = -6'sd1;
            min_next = 6'(mp + 8'sd60);
        end
        else if (mp >= 8'sd60)
        begin
            f        = 6'sd1;
            min_next = 6'(mp - 8'sd60);
        end
        else
        begin
            f        = 6'sd0;
            min_next = 6'(mp);
        end
        hh_s   = $signed({2'b00, whole});
        n_next = (neg ? -hh_s : hh_s) + f;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_min_reg <= min_next;
            s0_n_reg   <= n_next;
            s0_h_reg   <= utc_hour;
        end
    end

    // stage 1: hour wrap modulo 24, untouched when nothing carries
    mjdlt_pkg::mjdlt_tm_t tm_reg [1:mjdlt_pkg::MJDLT_STAGES-1];
    logic signed [7:0] v;
    logic [4:0]        hour_next;

    always_comb
    begin
        v = 8'sd24 + $signed({3'b000, s0_h_reg}) + 8'(s0_n_reg);
        if (s0_n_reg == 6'sd0)
        begin
            hour_next = s0_h_reg;
        end
        else if (v >= 8'sd48)
        begin
            hour_next = 5'(v - 8'sd48);
        end
        else if (v >= 8'sd24)
        begin
            hour_next = 5'(v - 8'sd24);
        end
        else
        begin
            hour_next = 5'(v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            tm_reg[1].hour   <= hour_next;
            tm_reg[1].minute <= s0_min_reg;
        end
        for (int k = 2; k < mjdlt_pkg::MJDLT_STAGES; k++)
        begin
            if (load[k])
            begin
                tm_reg[k] <= tm_reg[k-1];
            end
        end
    end

    assign tm = tm_reg[mjdlt_pkg::MJDLT_STAGES-1];

endmodule

[rtl/core/mjd_time_to_local_date_time_unit.sv]
// top level: broadcast mjd and utc time record to gregorian date and local time
// each accepted request passes through eight register stages before its result is valid
// throughput: one request per cycle unless req_stall is high; bubbles are squeezed out while the output stalls
// the stall chain runs back combinationally through all 8 stage valid bits
// reset (async, active low) clears the stage valid bits only; data regs are not reset
module mjd_time_to_local_date_time_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  mjdlt_pkg::mjdlt_req_t req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output mjdlt_pkg::mjdlt_rsp_t rsp_data
);

    mjdlt_pkg::mjdlt_ctl_t ctl;
    mjdlt_pkg::mjdlt_tm_t  tm;
    logic [11:0]           year;
    logic [3:0]            month;
    logic [4:0]            day;

    // handshake: per-stage valid bits and load enables
    mjdlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    // date path: cycle index, reciprocal year divide, month compares, final fields
    mjdlt_date u_date (
        .clk   (clk),
        .load  (ctl.load),
        .mjd   (req_data.mjd),
        .year  (year),
        .month (month),
        .day   (day)
    );

    // time path: offset and hour wrap in two stages, then delayed to match the date
    mjdlt_time u_time (
        .clk               (clk),
        .load              (ctl.load),
        .utc_hour          (req_data.utc_hour),
        .utc_minute        (req_data.utc_minute),
        .offset_present    (req_data.offset_present),
        .offset_negative   (req_data.offset_negative),
        .offset_half_hours (req_data.offset_half_hours),
        .tm                (tm)
    );

    // the date is never moved by an hour wrap, so the two paths simply merge
    always_comb
    begin
        rsp_data.year         = year;
        rsp_data.month        = month;
        rsp_data.day          = day;
        rsp_data.local_hour   = tm.hour;
        rsp_data.local_minute = tm.minute;
    end

    // the input is held off only when every stage holds a request
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (&ctl.valid))
        else $error("request stalled while a pipeline stage is empty");

    // the minute is always normalized
    a_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.local_minute < 6'd60))
        else $error("local minute out of range");

    // the month comes out in 1 to 12 and the day is at least 1 for every mjd
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.month >= 4'd1 && rsp_data.month <= 4'd12
                       && rsp_data.day >= 5'd1))
        else $error("month or day out of range");

    // a result that leaves with the stage before the last one empty is not followed by another result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !ctl.valid[mjdlt_pkg::MJDLT_STAGES-2])
        |=> !rsp_valid)
        else $error("result appeared without a request behind it");

endmodule
